FILE: hdl/assert_macros.svh
// Assertion macros for the buddy free-map block.
// Included by the top level; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BBRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbrc assertion failed");
// next-cycle implication
`define BBRC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbrc assertion failed");
`else
`define BBRC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BBRC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/bbrc_pkg.sv
// Shared types and codes for the buddy free-map block.
// No dependencies; used by bbrc_ctrl, bbrc_dpath and the top level.
package bbrc_pkg;

   localparam int ORDER_COUNT_DEF = 8;
   localparam int ADDR_BITS_DEF   = 8;

   localparam int FUNC_W   = 2;
   localparam int ORDER_W  = 3;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_SEED    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [ORDER_W-1:0] order;
      logic [POS_W-1:0]   block_pos;
   } req_type;

   typedef struct packed {
      logic [ORDER_W-1:0]  result_order;
      logic [POS_W-1:0]    result_pos;
      logic                is_free;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVAL,
      ST_BUD_READ,
      ST_BUD_EVAL,
      ST_FINAL,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_step;  // write zero at sweep address, advance sweep
      logic load_req;  // capture accepted request
      logic rd_bud;    // read buddy bit (otherwise own bit is read)
      logic eval;      // settle status from own bit
      logic merge;     // clear buddy bit, climb one order
      logic set_self;  // mark current block free
      logic load_rsp;  // move result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic bad;
      logic query;
      logic seed;
      logic map_bit;    // registered read data
      logic can_climb;  // current order below top
      logic climb_more; // order after a merge still below top
   } stat_type;

endpackage

FILE: hdl/buddy_block_release_coalesce_core.sv
// Buddy free map: seed, release with buddy coalescing, query. Seed, query and
// errors go from lookup and evaluation straight to the result; a release also
// probes buddies, reading each from the single-port free map and clearing it
// when free, up to min(ORDER_COUNT-1, ADDR_BITS) buddies, then marks its block.
// A new request is taken only once the previous result is loaded; rsp_stall holds that.
// After reset a sweep clears all 2^(ADDR_BITS+1) map bits (512), req_stall high.
`include "assert_macros.svh"

module buddy_block_release_coalesce_core #(
   parameter int ORDER_COUNT = bbrc_pkg::ORDER_COUNT_DEF,
   parameter int ADDR_BITS   = bbrc_pkg::ADDR_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bbrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bbrc_pkg::rsp_type rsp_data
);

   bbrc_pkg::cmd_type  cmd;
   bbrc_pkg::stat_type stat;

   bbrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bbrc_dpath #(
      .ORDER_COUNT (ORDER_COUNT),
      .ADDR_BITS   (ADDR_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // a merge only follows a buddy read that found the buddy free
   `BBRC_ASSERT_IMP(a_merge_needs_free, clock, reset, cmd.merge, stat.map_bit)
   // at most one map write source per cycle
   `BBRC_ASSERT_IMP(a_one_write, clock, reset, 1'b1,
                    $onehot0({cmd.clr_step, cmd.merge, cmd.set_self}))
   // once a request is taken the block is busy
   `BBRC_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   // loading a result makes it visible
   `BBRC_ASSERT_NXT(a_rsp_shown, clock, reset, cmd.load_rsp, rsp_valid)

endmodule

FILE: hdl/bbrc_ctrl.sv
// Sequencer for the buddy free-map block: clearing sweep, lookup, buddy climb.
// Depends on bbrc_pkg; drives commands into bbrc_dpath.
module bbrc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  bbrc_pkg::stat_type stat,
   output bbrc_pkg::cmd_type  cmd
);

   bbrc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                out_free;

   assign req_stall = (state_ff != bbrc_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bbrc_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = bbrc_pkg::ST_IDLE;
         end
         bbrc_pkg::ST_IDLE: begin
            if (accept) state_in = bbrc_pkg::ST_LOOKUP;
         end
         bbrc_pkg::ST_LOOKUP: begin
            state_in = bbrc_pkg::ST_EVAL;
         end
         bbrc_pkg::ST_EVAL: begin
            if (stat.bad || stat.query || stat.map_bit || stat.seed)
               state_in = bbrc_pkg::ST_DONE;
            else if (stat.can_climb)
               state_in = bbrc_pkg::ST_BUD_READ;
            else
               state_in = bbrc_pkg::ST_FINAL;
         end
         bbrc_pkg::ST_BUD_READ: begin
            state_in = bbrc_pkg::ST_BUD_EVAL;
         end
         bbrc_pkg::ST_BUD_EVAL: begin
            if (stat.map_bit && stat.climb_more)
               state_in = bbrc_pkg::ST_BUD_READ;
            else
               state_in = bbrc_pkg::ST_FINAL;
         end
         bbrc_pkg::ST_FINAL: begin
            state_in = bbrc_pkg::ST_DONE;
         end
         bbrc_pkg::ST_DONE: begin
            if (out_free) state_in = bbrc_pkg::ST_IDLE;
         end
         default: begin
            state_in = bbrc_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         bbrc_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         bbrc_pkg::ST_IDLE: begin
            cmd.load_req = accept;
         end
         bbrc_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            // seed of a valid, not yet free block writes in place
            cmd.set_self = stat.seed && !stat.bad && !stat.map_bit;
         end
         bbrc_pkg::ST_BUD_READ: begin
            cmd.rd_bud = 1'b1;
         end
         bbrc_pkg::ST_BUD_EVAL: begin
            cmd.merge = stat.map_bit;
         end
         bbrc_pkg::ST_FINAL: begin
            cmd.set_self = 1'b1;
         end
         bbrc_pkg::ST_DONE: begin
            cmd.load_rsp = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbrc_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/bbrc_dpath.sv
// Datapath for the buddy free-map block: free-map memory, index math,
// working order/address and the result register. Depends on bbrc_pkg.
module bbrc_dpath #(
   parameter int ORDER_COUNT = bbrc_pkg::ORDER_COUNT_DEF,
   parameter int ADDR_BITS   = bbrc_pkg::ADDR_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  bbrc_pkg::req_type  req_data,
   input  bbrc_pkg::cmd_type  cmd,
   output bbrc_pkg::stat_type stat,
   output bbrc_pkg::rsp_type  rsp_data
);

   localparam int MapAw    = ADDR_BITS + 1;
   localparam int MapDepth = 1 << MapAw;
   localparam int TopOrder = (ORDER_COUNT - 1 < ADDR_BITS) ? ORDER_COUNT - 1 : ADDR_BITS;
   localparam int KLog     = $clog2(TopOrder + 1);
   localparam int KW       = (KLog > bbrc_pkg::ORDER_W) ? KLog : bbrc_pkg::ORDER_W;

   logic                          free_map [MapDepth];

   logic [bbrc_pkg::FUNC_W-1:0]   func_ff;
   logic                          bad_ff;
   logic [KW-1:0]                 k_ff, k_in;
   logic [bbrc_pkg::POS_W-1:0]    p_ff, p_in;
   logic [bbrc_pkg::STATUS_W-1:0] status_ff;
   logic                          free_ff;
   logic                          rd_ff;
   logic [MapAw-1:0]              clr_cnt_ff;
   bbrc_pkg::rsp_type             rsp_ff;

   logic                          bad_in;
   logic [MapAw-1:0]              p_wide;
   logic [MapAw-1:0]              self_idx;
   logic [MapAw-1:0]              bud_idx;
   logic [MapAw-1:0]              mem_addr;
   logic                          mem_we;
   logic                          mem_wdata;

   // request check: order within top, address in range, aligned, func defined
   always_comb begin
      bad_in = (req_data.func == bbrc_pkg::FUNC_UNUSED)
            || (int'(req_data.order) > TopOrder)
            || ((32'(req_data.block_pos) >> ADDR_BITS) != 32'd0)
            || ((req_data.block_pos & ~({bbrc_pkg::POS_W{1'b1}} << req_data.order))
                != '0);
   end

   // order k lives at base (top k bits set) plus p >> k
   assign p_wide   = MapAw'(p_ff);
   assign self_idx = ({MapAw{1'b1}} << (MapAw - int'(k_ff))) + (p_wide >> k_ff);
   assign bud_idx  = ({MapAw{1'b1}} << (MapAw - int'(k_ff)))
                   + ((p_wide ^ (MapAw'(1) << k_ff)) >> k_ff);

   always_comb begin
      mem_we    = cmd.clr_step || cmd.merge || cmd.set_self;
      mem_wdata = cmd.set_self;
      if (cmd.clr_step)
         mem_addr = clr_cnt_ff;
      else if (cmd.merge || cmd.rd_bud)
         mem_addr = bud_idx;
      else
         mem_addr = self_idx;
   end

   always_ff @(posedge clock) begin
      if (mem_we) free_map[mem_addr] <= mem_wdata;
      rd_ff <= free_map[mem_addr];
   end

   always_comb begin
      k_in = k_ff;
      p_in = p_ff;
      if (cmd.load_req) begin
         k_in = KW'(req_data.order);
         p_in = req_data.block_pos;
      end else if (cmd.merge) begin
         k_in = k_ff + KW'(1);
         p_in = p_ff & ~(bbrc_pkg::POS_W'(1) << k_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         clr_cnt_ff <= '0;
      else if (cmd.clr_step)
         clr_cnt_ff <= clr_cnt_ff + MapAw'(1);
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      p_ff <= p_in;
      if (cmd.load_req) begin
         func_ff <= req_data.func;
         bad_ff  <= bad_in;
      end
      if (cmd.eval) begin
         free_ff <= !bad_ff && (func_ff == bbrc_pkg::FUNC_QUERY) && rd_ff;
         if (bad_ff)
            status_ff <= bbrc_pkg::STATUS_BAD;
         else if (func_ff == bbrc_pkg::FUNC_QUERY)
            status_ff <= bbrc_pkg::STATUS_OK;
         else if (rd_ff)
            status_ff <= bbrc_pkg::STATUS_ALREADY;
         else
            status_ff <= bbrc_pkg::STATUS_OK;
      end
      if (cmd.load_rsp) begin
         rsp_ff.result_order <= k_ff[bbrc_pkg::ORDER_W-1:0];
         rsp_ff.result_pos   <= p_ff;
         rsp_ff.is_free      <= free_ff;
         rsp_ff.status       <= status_ff;
      end
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      stat.clr_last   = &clr_cnt_ff;
      stat.bad        = bad_ff;
      stat.query      = (func_ff == bbrc_pkg::FUNC_QUERY);
      stat.seed       = (func_ff == bbrc_pkg::FUNC_SEED);
      stat.map_bit    = rd_ff;
      stat.can_climb  = int'(k_ff) < TopOrder;
      stat.climb_more = int'(k_ff) + 1 < TopOrder;
   end

endmodule

FILE: dv/tb_buddy_block_release_coalesce_core.sv
// Testbench for buddy_block_release_coalesce_core: seed, release with coalescing, query.
// Depends on bbrc_pkg and the core RTL; the scoreboard keeps its own copy of the free map.
`timescale 1ns / 100ps

module tb_buddy_block_release_coalesce_core;

   localparam int MAP_DEPTH = 1 << (bbrc_pkg::ADDR_BITS_DEF + 1);
   localparam int TOP_ORDER = (bbrc_pkg::ORDER_COUNT_DEF - 1 < bbrc_pkg::ADDR_BITS_DEF) ?
                              bbrc_pkg::ORDER_COUNT_DEF - 1 : bbrc_pkg::ADDR_BITS_DEF;
   localparam int ITEM_TARGET = 1900;
   localparam int CYCLE_LIMIT = 400000;

   class coalesce_scoreboard;
      bit                pending_dummy;
      bit                free_bits [MAP_DEPTH];
      bbrc_pkg::rsp_type pending_results [$];
      int unsigned       mismatches;

      function new();
         mismatches    = 0;
         pending_dummy = 1'b0;
         foreach (free_bits[i]) free_bits[i] = 1'b0;
      endfunction

      function int unsigned map_slot(int unsigned k, int unsigned p);
         return (MAP_DEPTH - (1 << (bbrc_pkg::ADDR_BITS_DEF + 1 - k)) + (p >> k))
                & (MAP_DEPTH - 1);
      endfunction

      task report(string what);
         $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      // Applies one request to the local free map and returns its response.
      function bbrc_pkg::rsp_type coalesce(bbrc_pkg::req_type r);
         bbrc_pkg::rsp_type o;
         int unsigned       k, p;
         bit                well_formed;
         k = r.order;
         p = r.block_pos;
         o.result_order = r.order;
         o.result_pos   = r.block_pos;
         o.is_free      = 1'b0;
         o.status       = bbrc_pkg::STATUS_OK;
         well_formed = (k <= TOP_ORDER) && (p < (1 << bbrc_pkg::ADDR_BITS_DEF))
                       && ((p & ((1 << k) - 1)) == 0);
         if (r.func == bbrc_pkg::FUNC_UNUSED || !well_formed) begin
            o.status = bbrc_pkg::STATUS_BAD;
         end else if (r.func == bbrc_pkg::FUNC_QUERY) begin
            o.is_free = free_bits[map_slot(k, p)];
         end else if (free_bits[map_slot(k, p)]) begin
            o.status = bbrc_pkg::STATUS_ALREADY;
         end else if (r.func == bbrc_pkg::FUNC_SEED) begin
            free_bits[map_slot(k, p)] = 1'b1;
         end else begin
            // climb while the buddy is free, never past the top order
            while (k < TOP_ORDER && free_bits[map_slot(k, p ^ (1 << k))]) begin
               free_bits[map_slot(k, p ^ (1 << k))] = 1'b0;
               p = p & ~(1 << k);
               k++;
            end
            free_bits[map_slot(k, p)] = 1'b1;
            o.result_order = k[bbrc_pkg::ORDER_W-1:0];
            o.result_pos   = p[bbrc_pkg::POS_W-1:0];
         end
         return o;
      endfunction

      function void note_request(bbrc_pkg::req_type r);
         pending_results.push_back(coalesce(r));
      endfunction

      task check_response(bbrc_pkg::rsp_type got);
         bbrc_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("response with nothing pending: %p", got));
            return;
         end
         want = pending_results.pop_front();
         if (got.result_order !== want.result_order)
            report($sformatf("result_order %0d, want %0d", got.result_order,
                             want.result_order));
         if (got.result_pos !== want.result_pos)
            report($sformatf("result_pos %0d, want %0d", got.result_pos, want.result_pos));
         if (got.is_free !== want.is_free)
            report($sformatf("is_free %0b, want %0b", got.is_free, want.is_free));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
      endtask
   endclass

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bbrc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bbrc_pkg::rsp_type rsp_data;

   coalesce_scoreboard sb = new();
   int unsigned        sent_count  = 0;
   int unsigned        cycle_count = 0;
   bit                 req_gaps    = 1'b1;
   bit                 rsp_gaps    = 1'b1;

   buddy_block_release_coalesce_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= rsp_gaps && ($urandom_range(0, 99) < 30);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_request(input logic [bbrc_pkg::FUNC_W-1:0] f, input int unsigned k,
                               input int unsigned p);
      @(negedge clock);
      while (req_gaps && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{func: f, order: k[bbrc_pkg::ORDER_W-1:0],
                     block_pos: p[bbrc_pkg::POS_W-1:0]};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // drop valid and hold off until every pending response is back
   task automatic drain_requests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // release (now and then query) every block of one order inside an aligned region, so buddies merge
   task automatic free_region_burst();
      int unsigned k, span, base, n, idx;
      bit          descend;
      k       = $urandom_range(0, 3);
      span    = $urandom_range(1, 3);
      n       = 1 << span;
      base    = $urandom_range(0, 255) & ~((1 << (k + span)) - 1);
      descend = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         idx = descend ? n - 1 - i : i;
         send_request($urandom_range(0, 9) == 0 ? bbrc_pkg::FUNC_QUERY : bbrc_pkg::FUNC_RELEASE,
                      k, base + (idx << k));
      end
   endtask

   task automatic random_request();
      int unsigned                 pick, k, fsel;
      logic [bbrc_pkg::FUNC_W-1:0] f;
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
         f = (pick < 40) ? bbrc_pkg::FUNC_RELEASE :
             (pick < 65) ? bbrc_pkg::FUNC_SEED : bbrc_pkg::FUNC_QUERY;
         k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
         send_request(f, k, $urandom_range(0, 255) & ~((1 << k) - 1));
      end else begin
         // noise: any selector, any order, any address
         fsel = $urandom_range(0, 3);
         send_request(fsel[bbrc_pkg::FUNC_W-1:0], $urandom_range(0, 7),
                      $urandom_range(0, 255));
      end
   endtask

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // buddies of block 0 at every order below the top, then one release merges to the top
      for (int k = 0; k < TOP_ORDER; k++) send_request(bbrc_pkg::FUNC_SEED, k, 1 << k);
      send_request(bbrc_pkg::FUNC_RELEASE, 0, 0);
      send_request(bbrc_pkg::FUNC_QUERY, 7, 0);
      send_request(bbrc_pkg::FUNC_QUERY, 6, 64);
      send_request(bbrc_pkg::FUNC_RELEASE, 7, 0);
      send_request(bbrc_pkg::FUNC_RELEASE, 7, 128);
      send_request(bbrc_pkg::FUNC_SEED, 7, 128);
      send_request(bbrc_pkg::FUNC_RELEASE, 0, 255);
      send_request(bbrc_pkg::FUNC_SEED, 0, 255);
      send_request(bbrc_pkg::FUNC_QUERY, 0, 255);
      send_request(bbrc_pkg::FUNC_UNUSED, 7, 255);
      send_request(bbrc_pkg::FUNC_RELEASE, 3, 4);
      send_request(bbrc_pkg::FUNC_SEED, 7, 255);
      send_request(bbrc_pkg::FUNC_QUERY, 1, 1);
      send_request(bbrc_pkg::FUNC_QUERY, 5, 224);

      while (sent_count < ITEM_TARGET) begin
         if (sent_count >= 700 && sent_count < 1000) begin
            req_gaps = 1'b0;
            rsp_gaps = 1'b0;
         end else begin
            req_gaps = 1'b1;
            rsp_gaps = 1'b1;
         end
         if (!paused && sent_count >= 1200) begin
            drain_requests();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 30) free_region_burst();
         else random_request();
      end

      drain_requests();
      repeat (40) @(posedge clock);
      if (sb.pending_results.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending_results.size()));
      if (sb.mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
